[sv/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants of the polygon plane clipper
// Field widths, derived arithmetic widths, register indexes and the command
// that travels from the classify front end to the clip back end.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int COORD_W    = 16;
  localparam int NORM_W     = 16;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (NORM_W > COORD_W) ? NORM_W : COORD_W;

  // distance arithmetic: normal times (vertex - origin), summed over three axes
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = NORM_W + DIFF_W;
  localparam int DIST_W = PROD_W + 3;
  localparam int MAG_W  = DIST_W;
  localparam int REM_W  = MAG_W + 2;
  localparam int QUOT_W = DIFF_W;

  localparam int NORM_ONE = 1 << (NORM_W - 2);

  localparam int IN_DATA_W     = ((3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = 3 * COORD_W + IDX_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int MAX_OUT_VERTICES_DEF = 36;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;

  typedef struct packed {
    norm_t  nx;
    norm_t  ny;
    norm_t  nz;
    coord_t ox;
    coord_t oy;
    coord_t oz;
  } plane_t;

  // lane 0 = x, 1 = y, 2 = z
  typedef struct packed {
    logic                    first;
    logic                    cross_edge;
    logic                    emit_cur;
    coord_t [2:0]            cur;
    coord_t [2:0]            prev;
    logic   [2:0]            diff_neg;
    logic   [2:0][DIFF_W-1:0] mdiff;
    logic   [MAG_W-1:0]      mdp;
    logic   [MAG_W-1:0]      mden;
  } cmd_t;

endpackage

[sv/polygon_plane_clipper_top.sv]
// ----------------------------------------------------------------------------
// polygon_plane_clipper_top: single-plane polygon clipper
// Streams polygon vertices in and clipped polygon vertices out, fixed point.
// ----------------------------------------------------------------------------
// Each input item is one vertex (Q8.8); tuser marks the first vertex of a
// polygon (0) or a following one (1). The block classifies every vertex by
// its signed distance to the configured plane (Q2.14 normal through a Q8.8
// origin) and emits zero, one or two vertices per item, numbered in clipped
// polygon order, tlast on the final one of each item, tuser set once the
// vertex limit is reached. The front end handles an item in the steps
// accept, multiply, sum, classify and hand over, and takes the next item
// only once the last has been handed over. A two-entry command queue then
// feeds the back end; an edge that crosses the plane runs through the
// bit-serial divider that forms the crossing point one quotient bit per
// cycle (17 steps, three axes side by side), and the back end takes the
// next command only once it is through with the last. A registered
// output stage lets the back end finish an item while its last result
// waits. Configuration writes are taken at any clock with cfg_we high and
// should only happen while idle.
// ----------------------------------------------------------------------------
module polygon_plane_clipper_top #(
  parameter int MAX_OUT_VERTICES = ppc_pkg::MAX_OUT_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input vertices
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ppc_pkg::IN_DATA_W-1:0]     in_tdata,   // pos_x, pos_y, pos_z
  input  logic [0:0]                        in_tuser,   // action
  // clipped vertices
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ppc_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_x, out_y, out_z, out_index
  output logic                              out_tlast,
  output logic [0:0]                        out_tuser,  // overflow
  // plane setup
  input  logic                              cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ppc_pkg::*;

  plane_t           plane_r;
  coord_t [2:0]     in_pos;
  coord_t [2:0]     out_pos;
  logic [IDX_W-1:0] out_idx;
  logic             q_push, q_pop, q_full, q_empty;
  cmd_t             q_in, q_out;

  // Plane registers; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.nx <= '0;
      plane_r.ny <= NORM_W'(NORM_ONE);
      plane_r.nz <= '0;
      plane_r.ox <= '0;
      plane_r.oy <= '0;
      plane_r.oz <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL_X: plane_r.nx <= cfg_wdata[NORM_W-1:0];
        CFG_NORMAL_Y: plane_r.ny <= cfg_wdata[NORM_W-1:0];
        CFG_NORMAL_Z: plane_r.nz <= cfg_wdata[NORM_W-1:0];
        CFG_ORIGIN_X: plane_r.ox <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Y: plane_r.oy <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Z: plane_r.oz <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the vertex, x in the lowest bits.
  always_comb begin
    for (int i = 0; i < 3; i++) in_pos[i] = in_tdata[i*COORD_W +: COORD_W];
  end

  ppc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .plane     (plane_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser[0]),
    .in_pos    (in_pos),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  ppc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  ppc_back #(
    .MAX_OUT_VERTICES (MAX_OUT_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pos   (out_pos),
    .out_idx   (out_idx),
    .out_last  (out_tlast),
    .out_over  (out_tuser[0])
  );

  // Pack the result, x lowest, index on top, zero fill to whole bytes.
  assign out_tdata = OUT_DATA_W'({out_idx, out_pos[2], out_pos[1], out_pos[0]});

endmodule

[sv/ppc_front.sv]
// ----------------------------------------------------------------------------
// ppc_front: vertex intake and classification
// Computes the signed plane distance, classifies the edge against the
// previous vertex and builds a clip command for the back end.
// ----------------------------------------------------------------------------
module ppc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppc_pkg::plane_t       plane,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  ppc_pkg::coord_t [2:0] in_pos,
  input  logic                  q_full,
  output logic                  q_push,
  output ppc_pkg::cmd_t         q_cmd
);
  import ppc_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_PREP = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic                      act_r;
  coord_t [2:0]              pos_r;
  coord_t [2:0]              prev_pos_r;
  logic signed [DIST_W-1:0]  prev_dist_r;
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [PROD_W-1:0]  prod_nxt [3];
  logic signed [DIST_W-1:0]  dc_r, dc_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  coord_t                    org [3];
  norm_t                     nrm [3];

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_cmd    = cmd_r;

  always_comb begin
    org[0] = plane.ox;
    org[1] = plane.oy;
    org[2] = plane.oz;
    nrm[0] = plane.nx;
    nrm[1] = plane.ny;
    nrm[2] = plane.nz;
  end

  always_comb begin
    logic signed [DIFF_W-1:0] rel;
    for (int i = 0; i < 3; i++) begin
      rel = $signed({pos_r[i][COORD_W-1], pos_r[i]}) - $signed({org[i][COORD_W-1], org[i]});
      prod_nxt[i] = nrm[i] * rel;
    end
    dc_nxt = DIST_W'(prod_r[0]) + DIST_W'(prod_r[1]) + DIST_W'(prod_r[2]);
  end

  always_comb begin
    logic                     cur_back;
    logic                     prev_back;
    logic signed [DIST_W:0]   den;
    logic signed [DIFF_W-1:0] d;
    cur_back  = dc_r[DIST_W-1];
    prev_back = prev_dist_r[DIST_W-1];
    den = $signed({prev_dist_r[DIST_W-1], prev_dist_r}) - $signed({dc_r[DIST_W-1], dc_r});
    cmd_nxt.first      = !act_r;
    cmd_nxt.cross_edge = act_r && (cur_back != prev_back);
    cmd_nxt.emit_cur   = !cur_back;
    cmd_nxt.cur        = pos_r;
    cmd_nxt.prev       = prev_pos_r;
    cmd_nxt.mdp        = prev_back ? MAG_W'(-prev_dist_r) : MAG_W'(prev_dist_r);
    cmd_nxt.mden       = den[DIST_W] ? MAG_W'(-den) : MAG_W'(den);
    for (int i = 0; i < 3; i++) begin
      d = $signed({pos_r[i][COORD_W-1], pos_r[i]})
        - $signed({prev_pos_r[i][COORD_W-1], prev_pos_r[i]});
      cmd_nxt.diff_neg[i] = d[DIFF_W-1];
      cmd_nxt.mdiff[i]    = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_SUM;
      F_SUM:   state_nxt = F_PREP;
      F_PREP:  state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      prev_pos_r  <= '0;
      prev_dist_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_PREP) begin
        prev_pos_r  <= pos_r;
        prev_dist_r <= dc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action;
      pos_r <= in_pos;
    end
    if (state_r == F_MUL) begin
      for (int i = 0; i < 3; i++) prod_r[i] <= prod_nxt[i];
    end
    if (state_r == F_SUM) dc_r <= dc_nxt;
    if (state_r == F_PREP) cmd_r <= cmd_nxt;
  end

endmodule

[sv/ppc_queue.sv]
// ----------------------------------------------------------------------------
// ppc_queue: command queue between front end and back end
// Small register FIFO so that classification and clipping stall apart.
// ----------------------------------------------------------------------------
module ppc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppc_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output ppc_pkg::cmd_t dout,
  output logic          empty
);
  import ppc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("command pushed into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("command popped from an empty queue");

endmodule

[sv/ppc_back.sv]
// ----------------------------------------------------------------------------
// ppc_back: clip execution and vertex output
// Runs the bit-serial intersection divider on crossing edges, numbers the
// emitted vertices and drives the output register.
// ----------------------------------------------------------------------------
module ppc_back #(
  parameter int MAX_OUT_VERTICES = ppc_pkg::MAX_OUT_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  ppc_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ppc_pkg::coord_t [2:0]            out_pos,
  output logic [ppc_pkg::IDX_W-1:0]        out_idx,
  output logic                             out_last,
  output logic                             out_over
);
  import ppc_pkg::*;

  localparam int CNT_W = $clog2(MAX_OUT_VERTICES + 1);
  localparam int BIT_W = $clog2(DIFF_W);

  localparam logic [1:0] B_IDLE   = 2'd0;
  localparam logic [1:0] B_DIV    = 2'd1;
  localparam logic [1:0] B_EMIT_X = 2'd2;
  localparam logic [1:0] B_EMIT_C = 2'd3;

  logic [1:0]        state_r, state_nxt;
  cmd_t              cmd_r;
  logic [BIT_W-1:0]  bit_r;
  logic [MAG_W-1:0]  rem_r [3];
  logic [MAG_W-1:0]  rem_nxt [3];
  logic [QUOT_W-1:0] quot_r [3];
  logic [QUOT_W-1:0] quot_nxt [3];
  logic [CNT_W-1:0]  count_r;

  logic              out_valid_r;
  coord_t [2:0]      out_pos_r, xpos;
  logic [IDX_W-1:0]  out_idx_r, idx;
  logic              out_last_r, out_over_r;

  logic              out_free, load, over;

  assign out_free = !out_valid_r || out_ready;
  assign load     = out_free && (state_r == B_EMIT_X || state_r == B_EMIT_C);
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  assign over = (count_r >= CNT_W'(MAX_OUT_VERTICES));
  assign idx  = over ? IDX_W'(MAX_OUT_VERTICES - 1) : IDX_W'(count_r);

  // one quotient bit per lane per cycle; running remainder may need up to
  // two subtractions of the divisor since the added multiple does not exceed it
  always_comb begin
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] dd1, dd2;
    dd1 = REM_W'(cmd_r.mden);
    dd2 = REM_W'({cmd_r.mden, 1'b0});
    for (int i = 0; i < 3; i++) begin
      r2 = REM_W'({rem_r[i], 1'b0}) + (cmd_r.mdiff[i][bit_r] ? REM_W'(cmd_r.mdp) : '0);
      if (r2 >= dd2) begin
        rem_nxt[i]  = MAG_W'(r2 - dd2);
        quot_nxt[i] = QUOT_W'({quot_r[i], 1'b0}) + QUOT_W'(2);
      end else if (r2 >= dd1) begin
        rem_nxt[i]  = MAG_W'(r2 - dd1);
        quot_nxt[i] = QUOT_W'({quot_r[i], 1'b0}) + QUOT_W'(1);
      end else begin
        rem_nxt[i]  = MAG_W'(r2);
        quot_nxt[i] = QUOT_W'({quot_r[i], 1'b0});
      end
    end
  end

  // step from the previous vertex toward the current one
  always_comb begin
    coord_t qq;
    for (int i = 0; i < 3; i++) begin
      qq = (cmd_r.mden == '0) ? '0 : coord_t'(quot_r[i][COORD_W-1:0]);
      xpos[i] = cmd_r.diff_neg[i] ? coord_t'(cmd_r.prev[i] - qq)
                                  : coord_t'(cmd_r.prev[i] + qq);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.cross_edge)    state_nxt = B_DIV;
          else if (q_cmd.emit_cur) state_nxt = B_EMIT_C;
        end
      end
      B_DIV:    if (bit_r == '0) state_nxt = B_EMIT_X;
      B_EMIT_X: if (out_free) state_nxt = cmd_r.emit_cur ? B_EMIT_C : B_IDLE;
      B_EMIT_C: if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_cmd.first) count_r <= '0;
      else if (load && !over)   count_r <= count_r + 1'b1;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
      bit_r <= BIT_W'(DIFF_W - 1);
      for (int i = 0; i < 3; i++) begin
        rem_r[i]  <= '0;
        quot_r[i] <= '0;
      end
    end else if (state_r == B_DIV) begin
      bit_r <= bit_r - 1'b1;
      for (int i = 0; i < 3; i++) begin
        rem_r[i]  <= rem_nxt[i];
        quot_r[i] <= quot_nxt[i];
      end
    end
    if (load) begin
      out_pos_r  <= (state_r == B_EMIT_X) ? xpos : cmd_r.cur;
      out_idx_r  <= idx;
      out_over_r <= over;
      out_last_r <= (state_r == B_EMIT_C) || !cmd_r.emit_cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos   = out_pos_r;
  assign out_idx   = out_idx_r;
  assign out_last  = out_last_r;
  assign out_over  = out_over_r;

  a_over_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_over_r) |-> (out_idx_r == IDX_W'(MAX_OUT_VERTICES - 1)))
    else $error("overflow vertex carries a wrong index");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_OUT_VERTICES))
    else $error("vertex count ran past the limit");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && bit_r == '0 && cmd_r.mden != '0)
      |=> (quot_r[0] <= cmd_r.mdiff[0]))
    else $error("intersection step exceeds the edge length");

endmodule
